@@ rtl/btmx_pkg.sv @@
// Shared types and constants for the binary trie maximum-XOR block.
// No dependencies; btmx_cell and binary_trie_max_xor import this package.
`timescale 1ns / 1ps
`default_nettype none
package btmx_pkg;

   localparam int FIELD_W = 31;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QREAD,
      ST_QSTEP,
      ST_QDRAIN,
      ST_QEND,
      ST_IREAD,
      ST_ISTEP,
      ST_IALLOC,
      ST_ILEAF,
      ST_DONE
   } btmx_state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } btmx_cell_ctl_type;

endpackage
`default_nettype wire

@@ rtl/btmx_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on nothing; field widths are fixed by the block's item format.
`timescale 1ns / 1ps
`default_nettype none
interface btmx_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [30:0] key_value;
   modport source (output valid, output mode, output key_value, input ready);
   modport sink (input valid, input mode, input key_value, output ready);
endinterface

interface btmx_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] best_xor;
   logic [30:0] running_max;
   logic        overflow;
   modport source (output valid, output best_xor, output running_max, output overflow,
                   input ready);
   modport sink (input valid, input best_xor, input running_max, input overflow,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/btmx_cell.sv @@
// One level cell of the key chain: holds a key bit and a result bit.
// Depends on btmx_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none
module btmx_cell
   import btmx_pkg::*;
(
   input  logic              clock,
   input  btmx_cell_ctl_type ctl,
   input  logic              load_key,
   input  logic              key_prev,
   input  logic              acc_prev,
   output logic              key_q,
   output logic              acc_q
);

   logic key_ff;
   logic acc_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff <= load_key;
         acc_ff <= 1'b0;
      end else if (ctl.shift) begin
         key_ff <= key_prev;
         acc_ff <= acc_prev;
      end
   end

   assign key_q = key_ff;
   assign acc_q = acc_ff;

endmodule
`default_nettype wire

@@ rtl/binary_trie_max_xor.sv @@
// A clear is answered in the cycle after it is accepted. One request is in flight at a time.
// An insert walks the trie for the query (per level below the root, a read state for the
// node store's single registered read port, then a step state), closes it in ST_QEND and,
// unless the store is too full, walks again to insert (a read and a step per existing level,
// an allocation state per new level, ST_ILEAF for the leaf); ST_DONE loads the response.
// Reset is synchronous: the trie is emptied and the running maximum zeroed.
// Depends on btmx_pkg, btmx_if and btmx_cell.
`timescale 1ns / 1ps
`default_nettype none
module binary_trie_max_xor
   import btmx_pkg::*;
#(
   parameter int KEY_BITS   = 31,
   parameter int NODE_COUNT = 65536
) (
   input  logic        clock,
   input  logic        reset,
   btmx_req_if.sink    req_port,
   btmx_rsp_if.source  rsp_port
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int LW = $clog2(KEY_BITS + 1);
   localparam int NW = 2 + 2 * IW;
   localparam logic [IW+1:0] NODES_W = (IW + 2)'(NODE_COUNT);
   localparam logic [IW+1:0] KEYS_W  = (IW + 2)'(KEY_BITS);

   btmx_state_type state_ff, state_in;
   logic [LW-1:0]  lvl_ff, lvl_in;
   logic [IW-1:0]  node_ff, node_in;
   logic [IW:0]    count_ff, count_in;
   logic [1:0]     root_v_ff, root_v_in;
   logic [IW-1:0]  root_c_ff [2];
   logic [IW-1:0]  root_c_in [2];
   logic [30:0]    max_ff, max_in;
   logic [30:0]    qbest_ff, qbest_in;
   logic           ovf_ff, ovf_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [30:0]    rsp_best_ff, rsp_best_in;
   logic [30:0]    rsp_max_ff, rsp_max_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic [NW-1:0]  mem [NODE_COUNT];
   logic [NW-1:0]  rd_ff;
   logic           mem_re, mem_we;
   logic [IW-1:0]  mem_wa;
   logic [NW-1:0]  mem_wd;

   btmx_cell_ctl_type   ctl;
   logic                acc_bit;
   logic [KEY_BITS-1:0] key_q, acc_q, load_bits;
   logic [30:0]         qbest_now;

   logic           accept, last, b, ovf_now;
   logic [1:0]     cur_v;
   logic [IW-1:0]  cur_c [2];
   logic [IW-1:0]  alloc_n;
   logic [IW+1:0]  free_nodes;

   assign accept = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.best_xor = rsp_best_ff;
   assign rsp_port.running_max = rsp_max_ff;
   assign rsp_port.overflow = rsp_ovf_ff;

   // Chain of level cells; the key rotates so it is intact for the insert walk.
   for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
      if (i < FIELD_W) begin : g_in
         assign load_bits[i] = req_port.key_value[i];
      end else begin : g_zero
         assign load_bits[i] = 1'b0;
      end
      if (i == 0) begin : g_first
         btmx_cell u_cell (
            .clock(clock), .ctl(ctl), .load_key(load_bits[i]),
            .key_prev(key_q[KEY_BITS-1]), .acc_prev(acc_bit),
            .key_q(key_q[i]), .acc_q(acc_q[i])
         );
      end else begin : g_next
         btmx_cell u_cell (
            .clock(clock), .ctl(ctl), .load_key(load_bits[i]),
            .key_prev(key_q[i-1]), .acc_prev(acc_q[i-1]),
            .key_q(key_q[i]), .acc_q(acc_q[i])
         );
      end
   end

   for (genvar i = 0; i < FIELD_W; i++) begin : g_best
      if (i < KEY_BITS) begin : g_bit
         assign qbest_now[i] = acc_q[i];
      end else begin : g_pad
         assign qbest_now[i] = 1'b0;
      end
   end

   assign b = key_q[KEY_BITS-1];
   assign last = (lvl_ff == '0);
   assign alloc_n = count_ff[IW-1:0];
   assign free_nodes = NODES_W - {1'b0, count_ff};
   assign ovf_now = (free_nodes < KEYS_W);

   // Node 0 is the root and lives in registers; all other nodes in the store.
   always_comb begin
      if (node_ff == '0) begin
         cur_v = root_v_ff;
         cur_c[0] = root_c_ff[0];
         cur_c[1] = root_c_ff[1];
      end else begin
         cur_v = rd_ff[NW-1:NW-2];
         cur_c[1] = rd_ff[2*IW-1:IW];
         cur_c[0] = rd_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[node_ff];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_port.mode == MODE_INSERT) begin
               state_in = (root_v_ff == 2'b00) ? ST_QDRAIN : ST_QSTEP;
            end
         end
         ST_QREAD:  state_in = ST_QSTEP;
         ST_QSTEP: begin
            if (last) begin
               state_in = ST_QEND;
            end else if (cur_v[!b] || cur_v[b]) begin
               state_in = ST_QREAD;
            end else begin
               state_in = ST_QDRAIN;
            end
         end
         ST_QDRAIN: state_in = last ? ST_QEND : ST_QDRAIN;
         ST_QEND:   state_in = ovf_now ? ST_DONE : ST_ISTEP;
         ST_IREAD:  state_in = ST_ISTEP;
         ST_ISTEP: begin
            if (cur_v[b]) begin
               state_in = last ? ST_DONE : ST_IREAD;
            end else begin
               state_in = last ? ST_ILEAF : ST_IALLOC;
            end
         end
         ST_IALLOC: state_in = last ? ST_ILEAF : ST_IALLOC;
         ST_ILEAF:  state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      lvl_in = lvl_ff;
      node_in = node_ff;
      count_in = count_ff;
      root_v_in = root_v_ff;
      root_c_in[0] = root_c_ff[0];
      root_c_in[1] = root_c_ff[1];
      max_in = max_ff;
      qbest_in = qbest_ff;
      ovf_in = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_best_in = rsp_best_ff;
      rsp_max_in = rsp_max_ff;
      rsp_ovf_in = rsp_ovf_ff;
      ctl = '0;
      acc_bit = 1'b0;
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_wa = node_ff;
      mem_wd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_port.mode == MODE_CLEAR) begin
                  root_v_in = 2'b00;
                  count_in = (IW + 1)'(1);
                  max_in = '0;
                  rsp_valid_in = 1'b1;
                  rsp_best_in = '0;
                  rsp_max_in = '0;
                  rsp_ovf_in = 1'b0;
               end else begin
                  ctl.load = 1'b1;
                  lvl_in = LW'(KEY_BITS - 1);
                  node_in = '0;
               end
            end
         end
         ST_QREAD, ST_IREAD: mem_re = 1'b1;
         ST_QSTEP: begin
            ctl.shift = 1'b1;
            lvl_in = lvl_ff - 1'b1;
            if (cur_v[!b]) begin
               acc_bit = 1'b1;
               node_in = cur_c[!b];
            end else if (cur_v[b]) begin
               node_in = cur_c[b];
            end
         end
         ST_QDRAIN: begin
            ctl.shift = 1'b1;
            lvl_in = lvl_ff - 1'b1;
         end
         ST_QEND: begin
            qbest_in = qbest_now;
            if (qbest_now > max_ff) begin
               max_in = qbest_now;
            end
            ovf_in = ovf_now;
            node_in = '0;
            lvl_in = LW'(KEY_BITS - 1);
         end
         ST_ISTEP: begin
            ctl.shift = 1'b1;
            lvl_in = lvl_ff - 1'b1;
            if (cur_v[b]) begin
               node_in = cur_c[b];
            end else begin
               // Link a fresh node under the current one, keeping its other link.
               if (node_ff == '0) begin
                  root_v_in[b] = 1'b1;
                  root_c_in[b] = alloc_n;
               end else begin
                  mem_we = 1'b1;
                  if (b) begin
                     mem_wd = {2'b10 | cur_v, alloc_n, cur_c[0]};
                  end else begin
                     mem_wd = {2'b01 | cur_v, cur_c[1], alloc_n};
                  end
               end
               node_in = alloc_n;
               count_in = count_ff + 1'b1;
            end
         end
         ST_IALLOC: begin
            // The current node is fresh, so only the new link is present.
            ctl.shift = 1'b1;
            lvl_in = lvl_ff - 1'b1;
            mem_we = 1'b1;
            if (b) begin
               mem_wd = {2'b10, alloc_n, {IW{1'b0}}};
            end else begin
               mem_wd = {2'b01, {IW{1'b0}}, alloc_n};
            end
            node_in = alloc_n;
            count_in = count_ff + 1'b1;
         end
         ST_ILEAF: begin
            mem_we = 1'b1;
            mem_wd = '0;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_best_in = qbest_ff;
            rsp_max_in = max_ff;
            rsp_ovf_in = ovf_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= (IW + 1)'(1);
         root_v_ff <= 2'b00;
         max_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         root_v_ff <= root_v_in;
         max_ff <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff <= lvl_in;
      node_ff <= node_in;
      root_c_ff[0] <= root_c_in[0];
      root_c_ff[1] <= root_c_in[1];
      qbest_ff <= qbest_in;
      ovf_ff <= ovf_in;
      rsp_best_ff <= rsp_best_in;
      rsp_max_ff <= rsp_max_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= NODES_W)
      else $error("node count beyond the node store");

   a_no_root_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_wa != '0)
      else $error("node store write to the root slot");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE) || rsp_valid_ff)
      else $error("accepted request neither started nor answered");

   a_max_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_port.ready |=> $stable(max_ff))
      else $error("running maximum changed while a response waits");
`endif

endmodule
`default_nettype wire
